[hdl/sasd_pkg.sv]
// sasd_pkg: sizes, codes and word helpers of the double-ended shared stack
// used by the channel interfaces, controller, datapath and checker
package sasd_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IO_BITS   = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_PUSH_L = 2'd0,
    OP_PUSH_R = 2'd1,
    OP_POP_L  = 2'd2,
    OP_POP_R  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic load_out;
  } sasd_cmd_t;

  // sign-extend the pushed word, then keep WORD_BITS bits
  function automatic word_t to_word(logic signed [IO_BITS-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[WORD_BITS-1:0];
  endfunction

  // sign-extend a stored word to the output width
  function automatic logic [IO_BITS-1:0] widen_word(word_t w);
    logic signed [WORD_BITS-1:0] s;
    logic signed [63:0]          ext;
    s   = w;
    ext = 64'(s);
    return ext[IO_BITS-1:0];
  endfunction

endpackage

[hdl/sasd_if.sv]
// sasd_in_if / sasd_out_if: valid/ready channels of the shared stack
// depends on sasd_pkg for payload widths
interface sasd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             operation;
  logic signed [sasd_pkg::IO_BITS-1:0]    push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface sasd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sasd_pkg::IO_BITS-1:0]    pop_value;
  logic [1:0]                             status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

[hdl/sasd_ctrl.sv]
// sasd_ctrl: two-state sequencer of the shared stack, owns the handshakes
// depends on sasd_pkg
module sasd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output sasd_pkg::sasd_cmd_t cmd
);
  import sasd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold here until the result slot is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/sasd_dp.sv]
// sasd_dp: word store, stack counts and result register of the shared stack
// depends on sasd_pkg; driven by sasd_ctrl commands
module sasd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sasd_pkg::sasd_cmd_t                 cmd,
  input  logic [1:0]                          operation,
  input  logic signed [sasd_pkg::IO_BITS-1:0] push_value,
  output logic signed [sasd_pkg::IO_BITS-1:0] pop_value,
  output logic [1:0]                          status
);
  import sasd_pkg::*;

  word_t mem [DEPTH];
  word_t rd_data_r;

  cnt_t  left_r, left_nxt;
  cnt_t  right_r, right_nxt;
  op_t   op_r;
  logic  full_r, empty_r;
  logic signed [IO_BITS-1:0] pop_value_r;
  logic [1:0]                status_r;

  op_t            op_in;
  logic [CNT_W:0] used;
  logic           full, empty;
  logic           wr_en, rd_en;
  cnt_t           wr_pos, rd_pos;
  idx_t           wr_addr, rd_addr;
  logic           is_pop;
  status_t        st;

  assign op_in = op_t'(operation);
  assign used  = {1'b0, left_r} + {1'b0, right_r};
  assign full  = used >= (CNT_W + 1)'(DEPTH);

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_pos    = left_r;
    rd_pos    = left_r - cnt_t'(1);
    empty     = 1'b0;
    unique case (op_in)
      OP_PUSH_L: begin
        wr_pos = left_r;
        if (!full) begin
          wr_en    = cmd.accept;
          left_nxt = left_r + cnt_t'(1);
        end
      end
      OP_PUSH_R: begin
        wr_pos = cnt_t'(DEPTH - 1) - right_r;
        if (!full) begin
          wr_en     = cmd.accept;
          right_nxt = right_r + cnt_t'(1);
        end
      end
      OP_POP_L: begin
        rd_pos = left_r - cnt_t'(1);
        empty  = (left_r == '0);
        if (!empty) begin
          rd_en    = cmd.accept;
          left_nxt = left_r - cnt_t'(1);
        end
      end
      OP_POP_R: begin
        rd_pos = cnt_t'(DEPTH) - right_r;
        empty  = (right_r == '0);
        if (!empty) begin
          rd_en     = cmd.accept;
          right_nxt = right_r - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  assign wr_addr = wr_pos[IDX_W-1:0];
  assign rd_addr = rd_pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= to_word(push_value);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (cmd.accept) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  // decision of the accepted item, registered at accept for the result load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= op_in;
      full_r  <= full;
      empty_r <= empty;
    end
  end

  assign is_pop = (op_r == OP_POP_L) || (op_r == OP_POP_R);

  always_comb begin
    priority if (is_pop && empty_r) begin
      st = ST_EMPTY;
    end else if (!is_pop && full_r) begin
      st = ST_FULL;
    end else begin
      st = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= st;
      priority if (is_pop && empty_r) begin
        pop_value_r <= '1;
      end else if (is_pop) begin
        pop_value_r <= widen_word(rd_data_r);
      end else begin
        pop_value_r <= '0;
      end
    end
  end

  assign pop_value = pop_value_r;
  assign status    = status_r;

endmodule

[hdl/shared_array_double_stack.sv]
// shared_array_double_stack: two LIFO stacks growing toward each other in one store
// depends on sasd_pkg, sasd_if, sasd_ctrl and sasd_dp
//
//   port     direction  fields                         role
//   in_ch    sink       operation[1:0], push_value[31:0]  push/pop request item
//   out_ch   source     pop_value[31:0], status[1:0]      one result item per request
//
// for each item the accept edge writes or reads the word store and moves a stack
// count; the sequencer loads the result register from S_EXEC once the result slot
// is free, so each item makes a single store access followed by the result load
// synchronous active-low reset clears the counts and handshake state only; the
// store holds whatever it held and is never read before a push writes it
// a result waiting in the output register does not block the next request; that
// request then holds in S_EXEC until the result slot frees
module shared_array_double_stack (
  input  logic       clk,
  input  logic       rst_n,
  sasd_in_if.sink    in_ch,
  sasd_out_if.source out_ch
);
  import sasd_pkg::*;

  sasd_cmd_t cmd;

  sasd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  sasd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .operation  (in_ch.operation),
    .push_value (in_ch.push_value),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status)
  );

endmodule

[hdl/sasd_checker.sv]
// sasd_checker: port-level assertions for shared_array_double_stack, bound to the top
// depends on sasd_pkg
module sasd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [sasd_pkg::IO_BITS-1:0] pop_value,
  input logic [1:0]                          status
);
  import sasd_pkg::*;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status))
    else $error("result dropped or changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still executing");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_DONE || status == ST_FULL || status == ST_EMPTY)
    else $error("undefined status code");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> pop_value == -1)
    else $error("empty pop without all-ones value");

  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> pop_value == 0)
    else $error("refused push with nonzero value");

endmodule

bind shared_array_double_stack sasd_checker u_sasd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pop_value (out_ch.pop_value),
  .status    (out_ch.status)
);
